FILE: rtl/core/pdro_pkg.sv
package pdro_pkg;

	// Field widths
	localparam int CMD_W   = 1;
	localparam int SENS_W  = 24;
	localparam int STEP_W  = 20;
	localparam int POS_W   = 32;
	localparam int HEAD_W  = 19;
	localparam int STAT_W  = 2;
	localparam int AGE_W   = 21;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;

	// Arithmetic unit widths
	localparam int MUL_A_W = 45;
	localparam int MUL_B_W = 33;
	localparam int PROD_W  = 64;
	localparam int NUM_W   = 64;
	localparam int DEN_W   = 41;
	localparam int CRD_W   = 34;

	localparam int CORDIC_STEPS_DEF = 16;

	// Item kinds
	localparam logic [CMD_W-1:0] CMD_SENSOR = 1'b0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_STALE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE    = 2'd1;

	localparam logic [CFG_DAT_W-1:0] MAX_STEP_RST = 20'd100000;
	localparam logic [CFG_DAT_W-1:0] STALE_RST    = 20'd100000;

	// Angle and scaling constants
	localparam int PI_Q16     = 205887;
	localparam int TWO_PI_Q16 = 411775;
	localparam logic signed [CRD_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [CRD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [64:0] DIV_1E6  = 65'sd1000000;
	localparam logic signed [64:0] DIV_2E12 = 65'sd2000000000000;

	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic signed [SENS_W-1:0] sat24(input logic signed [47:0] v);
		logic signed [SENS_W-1:0] r;
		if (v > 48'sd8388607)
			r = 24'sh7FFFFF;
		else if (v < -48'sd8388608)
			r = 24'sh800000;
		else
			r = v[SENS_W-1:0];
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [47:0] v);
		logic signed [POS_W-1:0] r;
		if (v > 48'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -48'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

endpackage

FILE: rtl/core/pdro_if.sv
interface pdro_item_if import pdro_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [SENS_W-1:0] accel_x;
	logic signed [SENS_W-1:0] accel_y;
	logic signed [SENS_W-1:0] vel_x_in;
	logic signed [SENS_W-1:0] vel_y_in;
	logic signed [SENS_W-1:0] yaw_rate_in;
	logic [STEP_W-1:0]        step_time;

	modport source (output valid, cmd, accel_x, accel_y, vel_x_in, vel_y_in, yaw_rate_in,
		step_time, input ready);
	modport sink (input valid, cmd, accel_x, accel_y, vel_x_in, vel_y_in, yaw_rate_in,
		step_time, output ready);
endinterface

interface pdro_pose_if import pdro_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [HEAD_W-1:0] heading;
	logic signed [SENS_W-1:0] vel_x_out;
	logic signed [SENS_W-1:0] vel_y_out;
	logic signed [SENS_W-1:0] yaw_rate_out;
	logic [STAT_W-1:0]        status;

	modport source (output valid, pos_x, pos_y, heading, vel_x_out, vel_y_out, yaw_rate_out,
		status, input ready);
	modport sink (input valid, pos_x, pos_y, heading, vel_x_out, vel_y_out, yaw_rate_out,
		status, output ready);
endinterface

interface pdro_cfg_if import pdro_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/planar_dead_reckoning_odometry_top.sv
// Planar dead-reckoning odometry.
// Channels: item (sink) takes sensor beats (cmd sensor) and tick beats (cmd tick);
// pose (source) gives one beat per tick with position, heading, velocities, status;
// cfg (sink) writes max_step_us (index 0) and stale_limit_us (index 1), always ready.
// A sensor beat is taken while the sequencer idles and gives no result.
// A tick that is out of range or stale goes straight to the emit state, with no unit run.
// A tick that integrates runs a sequencer over one shared shift-add multiplier
// (eleven products), one shared restoring divider by a constant (seven quotients
// plus one more when the heading wraps) and one iterative CORDIC, and then loads
// the pose beat into the output register.
// One item is in work at a time; item.ready is high only while the sequencer idles.
// The result beat sits in an output register: while pose stalls the block still
// takes the next item and works on it, and holds before its own result until the
// register frees up.
// Reset clears pose, velocities and sensor age, loads both limits with 100000 us,
// and drops any pending result beat.
module planar_dead_reckoning_odometry_top import pdro_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	pdro_cfg_if.sink   cfg,
	pdro_item_if.sink  item,
	pdro_pose_if.source pose
);

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
	localparam logic [ST_W-1:0] ST_M_VX  = 5'd1;
	localparam logic [ST_W-1:0] ST_D_VX  = 5'd2;
	localparam logic [ST_W-1:0] ST_M_AX  = 5'd3;
	localparam logic [ST_W-1:0] ST_D_AX  = 5'd4;
	localparam logic [ST_W-1:0] ST_M_AX2 = 5'd5;
	localparam logic [ST_W-1:0] ST_D_AX2 = 5'd6;
	localparam logic [ST_W-1:0] ST_M_VY  = 5'd7;
	localparam logic [ST_W-1:0] ST_D_VY  = 5'd8;
	localparam logic [ST_W-1:0] ST_M_AY  = 5'd9;
	localparam logic [ST_W-1:0] ST_D_AY  = 5'd10;
	localparam logic [ST_W-1:0] ST_M_AY2 = 5'd11;
	localparam logic [ST_W-1:0] ST_D_AY2 = 5'd12;
	localparam logic [ST_W-1:0] ST_M_YAW = 5'd13;
	localparam logic [ST_W-1:0] ST_D_YAW = 5'd14;
	localparam logic [ST_W-1:0] ST_CORD  = 5'd15;
	localparam logic [ST_W-1:0] ST_M_PXA = 5'd16;
	localparam logic [ST_W-1:0] ST_M_PXB = 5'd17;
	localparam logic [ST_W-1:0] ST_M_PYA = 5'd18;
	localparam logic [ST_W-1:0] ST_M_PYB = 5'd19;
	localparam logic [ST_W-1:0] ST_WRAP  = 5'd20;
	localparam logic [ST_W-1:0] ST_EMIT  = 5'd21;

	localparam int HN_W = 27;
	localparam logic signed [HN_W-1:0] PI_H = HN_W'(PI_Q16);
	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// Sequencer and architectural state
	logic [ST_W-1:0]          st_q;
	logic                     ph_q;
	logic [STAT_W-1:0]        status_q;
	logic [STEP_W-1:0]        t_q;
	logic [AGE_W-1:0]         age_q;
	logic [CFG_DAT_W-1:0]     max_step_q;
	logic [CFG_DAT_W-1:0]     stale_q;
	logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
	logic signed [HEAD_W-1:0] head_q;
	logic signed [SENS_W-1:0] vel_x_q, vel_y_q, yaw_q, acc_x_q, acc_y_q;

	// Work registers
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [MUL_A_W-1:0] at_q;
	logic signed [45:0]        dacc_q;
	logic signed [POS_W-1:0]   dx_q, dy_q;
	logic signed [HN_W-1:0]    hn_q;
	logic signed [PROD_W-1:0]  pacc_q;
	logic                      rnd_neg_q;

	// Output register
	logic                     out_valid_q;
	logic signed [POS_W-1:0]  o_px_q, o_py_q;
	logic signed [HEAD_W-1:0] o_head_q;
	logic signed [SENS_W-1:0] o_vx_q, o_vy_q, o_yaw_q;
	logic [STAT_W-1:0]        o_stat_q;

	// Unit hookup
	logic                      mul_start, mul_done;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic                      div_start, div_done;
	logic [NUM_W-1:0]          div_num, div_quo;
	logic [DEN_W-1:0]          div_den, div_rem;
	logic                      cord_start, cord_done;
	logic signed [CRD_W-1:0]   cord_c, cord_s;

	logic                  is_mul, is_rdiv, op_done;
	logic                  wrap_hi, wrap_lo;
	logic [AGE_W:0]        age_sum;
	logic [AGE_W-1:0]      age_next;
	logic                  step_bad, stale_hit;
	logic signed [64:0]    rnd_d, rnd_m, rnd_mag, rq;
	logic signed [HN_W:0]  wrap_num;
	logic signed [20:0]    wrap_res;
	logic signed [64:0]    pos_sum, pos_sh;
	logic signed [POS_W-1:0] pos_new;
	logic                  out_load;

	assign is_mul = st_q inside {ST_M_VX, ST_M_AX, ST_M_AX2, ST_M_VY, ST_M_AY, ST_M_AY2,
		ST_M_YAW, ST_M_PXA, ST_M_PXB, ST_M_PYA, ST_M_PYB};
	assign is_rdiv = st_q inside {ST_D_VX, ST_D_AX, ST_D_AX2, ST_D_VY, ST_D_AY, ST_D_AY2,
		ST_D_YAW};

	assign wrap_hi = hn_q > PI_H;
	assign wrap_lo = hn_q < -PI_H;

	assign mul_start  = is_mul && !ph_q;
	assign div_start  = !ph_q && (is_rdiv || ((st_q == ST_WRAP) && (wrap_hi || wrap_lo)));
	assign cord_start = (st_q == ST_CORD) && !ph_q;
	assign op_done    = mul_done || div_done || cord_done;

	// Sensor age saturates at its top value
	assign age_sum   = {1'b0, age_q} + (AGE_W + 1)'(item.step_time);
	assign age_next  = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
	assign step_bad  = (item.step_time == '0) || (item.step_time >= max_step_q);
	assign stale_hit = age_next >= AGE_W'(stale_q);

	// Multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = $signed(MUL_B_W'(t_q));
		case (st_q)
			ST_M_VX:  mul_a = MUL_A_W'(vel_x_q);
			ST_M_AX:  mul_a = MUL_A_W'(acc_x_q);
			ST_M_AX2: mul_a = at_q;
			ST_M_VY:  mul_a = MUL_A_W'(vel_y_q);
			ST_M_AY:  mul_a = MUL_A_W'(acc_y_q);
			ST_M_AY2: mul_a = at_q;
			ST_M_YAW: mul_a = MUL_A_W'(yaw_q);
			ST_M_PXA: begin
				mul_a = MUL_A_W'(dx_q);
				mul_b = $signed(cord_c[MUL_B_W-1:0]);
			end
			ST_M_PXB: begin
				mul_a = MUL_A_W'(dy_q);
				mul_b = $signed(cord_s[MUL_B_W-1:0]);
			end
			ST_M_PYA: begin
				mul_a = MUL_A_W'(dx_q);
				mul_b = $signed(cord_s[MUL_B_W-1:0]);
			end
			ST_M_PYB: begin
				mul_a = MUL_A_W'(dy_q);
				mul_b = $signed(cord_c[MUL_B_W-1:0]);
			end
			default: mul_a = '0;
		endcase
	end

	// Rounded division: floor((n + d/2) / d) through an unsigned divider on the magnitude
	assign rnd_d   = ((st_q == ST_D_AX2) || (st_q == ST_D_AY2)) ? DIV_2E12 : DIV_1E6;
	assign rnd_m   = 65'(prod_q) + (rnd_d >>> 1);
	assign rnd_mag = rnd_m[64] ? (rnd_d - 65'sd1 - rnd_m) : rnd_m;
	assign rq      = rnd_neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

	// Heading wrap: the remainder of the shifted heading gives the wrapped value
	assign wrap_num = wrap_hi ? ((HN_W + 1)'(hn_q) + (HN_W + 1)'(PI_H))
		: ((HN_W + 1)'(PI_H) - (HN_W + 1)'(hn_q));
	assign wrap_res = wrap_hi ? ($signed({1'b0, div_rem[19:0]}) - 21'(PI_Q16))
		: (21'(PI_Q16) - $signed({1'b0, div_rem[19:0]}));

	assign div_num = (st_q == ST_WRAP) ? NUM_W'(wrap_num) : rnd_mag[NUM_W-1:0];
	assign div_den = (st_q == ST_WRAP) ? DEN_W'(TWO_PI_Q16) : rnd_d[DEN_W-1:0];

	// Rotation into the world frame, rounded at bit 30
	assign pos_sum = (st_q == ST_M_PXB)
		? (65'(pacc_q) - 65'(mul_p) + 65'sd536870912)
		: (65'(pacc_q) + 65'(mul_p) + 65'sd536870912);
	assign pos_sh  = pos_sum >>> 30;
	assign pos_new = sat32(48'((st_q == ST_M_PXB) ? pos_x_q : pos_y_q)
		+ $signed(pos_sh[47:0]));

	pdro_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	pdro_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	pdro_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (head_q),
		.done   (cord_done),
		.cos_v  (cord_c),
		.sin_v  (cord_s)
	);

	// Work registers: products, partial sums, rounding sign
	always_ff @(posedge clk) begin
		if (div_start)
			rnd_neg_q <= rnd_m[64];
		if (ph_q && op_done) begin
			case (st_q)
				ST_M_AX, ST_M_AY: begin
					prod_q <= mul_p;
					at_q   <= mul_p[MUL_A_W-1:0];
				end
				ST_M_VX, ST_M_AX2, ST_M_VY, ST_M_AY2, ST_M_YAW: prod_q <= mul_p;
				ST_M_PXA, ST_M_PYA: pacc_q <= mul_p;
				ST_D_VX, ST_D_VY: dacc_q <= rq[45:0];
				ST_D_AX2: dx_q <= sat32(48'(dacc_q) + $signed(rq[47:0]));
				ST_D_AY2: dy_q <= sat32(48'(dacc_q) + $signed(rq[47:0]));
				ST_D_YAW: hn_q <= HN_W'(head_q) + $signed(rq[HN_W-1:0]);
				default: ;
			endcase
		end
	end

	// Sequencer, limits and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			ph_q       <= 1'b0;
			status_q   <= STAT_OK;
			t_q        <= '0;
			age_q      <= '0;
			max_step_q <= MAX_STEP_RST;
			stale_q    <= STALE_RST;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			head_q     <= '0;
			vel_x_q    <= '0;
			vel_y_q    <= '0;
			yaw_q      <= '0;
			acc_x_q    <= '0;
			acc_y_q    <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_MAX_STEP: max_step_q <= cfg.data;
					CFG_STALE:    stale_q    <= cfg.data;
					default: ;
				endcase
			end

			case (st_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (item.cmd == CMD_SENSOR) begin
							// latch the sample, data are fresh again
							acc_x_q <= item.accel_x;
							acc_y_q <= item.accel_y;
							vel_x_q <= item.vel_x_in;
							vel_y_q <= item.vel_y_in;
							yaw_q   <= item.yaw_rate_in;
							age_q   <= '0;
						end else begin
							t_q   <= item.step_time;
							age_q <= age_next;
							if (step_bad) begin
								status_q <= STAT_RANGE;
								st_q     <= ST_EMIT;
							end else if (stale_hit) begin
								status_q <= STAT_STALE;
								st_q     <= ST_EMIT;
							end else begin
								status_q <= STAT_OK;
								st_q     <= ST_M_VX;
							end
						end
					end
				end
				ST_EMIT: begin
					if (out_load)
						st_q <= ST_IDLE;
				end
				default: begin
					if (!ph_q) begin
						// launch the unit; a heading already in range skips the divide
						if ((st_q == ST_WRAP) && !(wrap_hi || wrap_lo)) begin
							head_q <= hn_q[HEAD_W-1:0];
							st_q   <= st_q + 1'b1;
						end else begin
							ph_q <= 1'b1;
						end
					end else if (op_done) begin
						ph_q <= 1'b0;
						st_q <= st_q + 1'b1;
						case (st_q)
							ST_D_AX:  vel_x_q <= sat24(48'(vel_x_q) + $signed(rq[47:0]));
							ST_D_AY:  vel_y_q <= sat24(48'(vel_y_q) + $signed(rq[47:0]));
							ST_M_PXB: pos_x_q <= pos_new;
							ST_M_PYB: pos_y_q <= pos_new;
							ST_WRAP:  head_q  <= wrap_res[HEAD_W-1:0];
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	// Result register: load when free or being taken, drop valid once taken
	assign out_load = (st_q == ST_EMIT) && (!out_valid_q || pose.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (pose.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_px_q   <= pos_x_q;
			o_py_q   <= pos_y_q;
			o_head_q <= head_q;
			o_vx_q   <= vel_x_q;
			o_vy_q   <= vel_y_q;
			o_yaw_q  <= yaw_q;
			o_stat_q <= status_q;
		end
	end

	assign cfg.ready  = 1'b1;
	assign item.ready = (st_q == ST_IDLE);

	assign pose.valid        = out_valid_q;
	assign pose.pos_x        = o_px_q;
	assign pose.pos_y        = o_py_q;
	assign pose.heading      = o_head_q;
	assign pose.vel_x_out    = o_vx_q;
	assign pose.vel_y_out    = o_vy_q;
	assign pose.yaw_rate_out = o_yaw_q;
	assign pose.status       = o_stat_q;

endmodule

FILE: rtl/core/pdro_mul.sv
module pdro_mul import pdro_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic                      done,
	output logic signed [PROD_W-1:0]  p
);

	localparam int BW = MUL_B_W - 1;
	localparam int CW = $clog2(BW);

	logic [MUL_A_W-1:0] a_mag;
	logic [BW-1:0]      b_mag;
	logic [PROD_W-1:0]  acc_q;
	logic [PROD_W-1:0]  ash_q;
	logic [BW-1:0]      bsh_q;
	logic [CW-1:0]      cnt_q;
	logic               neg_q;
	logic               busy_q;
	logic               done_q;

	assign a_mag = a[MUL_A_W-1] ? MUL_A_W'(-a) : MUL_A_W'(a);
	assign b_mag = b[MUL_B_W-1] ? BW'(-b) : BW'(b);

	// one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ash_q <= PROD_W'(a_mag);
			bsh_q <= b_mag;
			neg_q <= a[MUL_A_W-1] ^ b[MUL_B_W-1];
		end else if (busy_q) begin
			if (bsh_q[0])
				acc_q <= acc_q + ash_q;
			ash_q <= {ash_q[PROD_W-2:0], 1'b0};
			bsh_q <= {1'b0, bsh_q[BW-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(BW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign p    = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

FILE: rtl/core/pdro_div.sv
module pdro_div import pdro_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CW = $clog2(NUM_W);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/pdro_cordic.sv
module pdro_cordic import pdro_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [HEAD_W-1:0] angle,
	output logic                     done,
	output logic signed [CRD_W-1:0]  cos_v,
	output logic signed [CRD_W-1:0]  sin_v
);

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic signed [CRD_W-1:0] z_init;
	logic signed [CRD_W-1:0] z_fold;
	logic                    fold;
	logic signed [CRD_W-1:0] x_q, y_q, z_q;
	logic signed [CRD_W-1:0] xs, ys, at;
	logic                    neg_q;
	logic [IW-1:0]           it_q;
	logic                    busy_q;
	logic                    done_q;

	assign z_init = CRD_W'(angle) <<< 14;

	// fold into the right half plane, negate the result afterwards
	always_comb begin
		fold   = 1'b0;
		z_fold = z_init;
		if (z_init > HALF_PI_Q30) begin
			z_fold = z_init - PI_Q30;
			fold   = 1'b1;
		end else if (z_init < -HALF_PI_Q30) begin
			z_fold = z_init + PI_Q30;
			fold   = 1'b1;
		end
	end

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign at = $signed(CRD_W'(atan_q30(5'(it_q))));

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z_fold;
			neg_q <= fold;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= busy_q && (it_q == IW'(STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == IW'(STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done  = done_q;
	assign cos_v = neg_q ? -x_q : x_q;
	assign sin_v = neg_q ? -y_q : y_q;

endmodule

FILE: sim/pdro_pose_checker.sv
`timescale 1ns / 100ps

module pdro_pose_checker import pdro_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	pdro_cfg_if   cfg,
	pdro_item_if  item,
	pdro_pose_if  pose,
	output int    errors,
	output int    pending
);

	typedef struct packed {
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [HEAD_W-1:0] hd;
		logic signed [SENS_W-1:0] vx;
		logic signed [SENS_W-1:0] vy;
		logic signed [SENS_W-1:0] yr;
		logic [STAT_W-1:0]        st;
	} pose_beat_t;

	localparam longint USEC = 1000000;
	localparam longint USEC2X2 = 64'sd2000000000000;
	localparam longint AGE_CAP = 2097151;

	pose_beat_t pose_due[$];

	longint lim_step, lim_stale;
	longint pos_x, pos_y, head, vel_x, vel_y, yaw, acc_x, acc_y;
	longint age;

	function automatic longint floor_quot(longint n, longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint round_quot(longint n, longint d);
		return floor_quot(n + d / 2, d);
	endfunction

	function automatic longint clip(longint v, int w);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// Rotation-mode CORDIC on the heading, result in Q2.30
	task automatic heading_sincos(input longint h, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = h * 16384;
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(atan_q30(5'(i)));
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(atan_q30(5'(i)));
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// Advance the age and, for an in-range fresh tick, the pose; return the beat it should produce
	task automatic integrate_tick(input longint t, output pose_beat_t r);
		longint dx, dy, dth, c, s;
		logic signed [127:0] wx, wy;
		age = (age + t > AGE_CAP) ? AGE_CAP : age + t;
		if (t == 0 || t >= lim_step) begin
			r.st = STAT_RANGE;
		end else if (age >= lim_stale) begin
			r.st = STAT_STALE;
		end else begin
			dx = clip(round_quot(vel_x * t, USEC) + round_quot(acc_x * t * t, USEC2X2), 32);
			dy = clip(round_quot(vel_y * t, USEC) + round_quot(acc_y * t * t, USEC2X2), 32);
			dth = round_quot(yaw * t, USEC);
			vel_x = clip(vel_x + round_quot(acc_x * t, USEC), 24);
			vel_y = clip(vel_y + round_quot(acc_y * t, USEC), 24);
			heading_sincos(head, c, s);
			wx = 128'(dx) * 128'(c) - 128'(dy) * 128'(s) + (128'sd1 <<< 29);
			wy = 128'(dx) * 128'(s) + 128'(dy) * 128'(c) + (128'sd1 <<< 29);
			pos_x = clip(pos_x + longint'(wx >>> 30), 32);
			pos_y = clip(pos_y + longint'(wy >>> 30), 32);
			head = head + dth;
			if (head > PI_Q16)
				head -= ((head - PI_Q16 + TWO_PI_Q16 - 1) / TWO_PI_Q16) * TWO_PI_Q16;
			else if (head < -PI_Q16)
				head += ((-PI_Q16 - head + TWO_PI_Q16 - 1) / TWO_PI_Q16) * TWO_PI_Q16;
			r.st = STAT_OK;
		end
		r.px = pos_x[POS_W-1:0];
		r.py = pos_y[POS_W-1:0];
		r.hd = head[HEAD_W-1:0];
		r.vx = vel_x[SENS_W-1:0];
		r.vy = vel_y[SENS_W-1:0];
		r.yr = yaw[SENS_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_beat_t want, got;
		if (!arst_n) begin
			lim_step = MAX_STEP_RST;
			lim_stale = STALE_RST;
			pos_x = 0; pos_y = 0; head = 0;
			vel_x = 0; vel_y = 0; yaw = 0;
			acc_x = 0; acc_y = 0; age = 0;
			pose_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			// Results come from older ticks, so retire before taking a new item
			if (pose.valid && pose.ready) begin
				got = '{pose.pos_x, pose.pos_y, pose.heading, pose.vel_x_out,
					pose.vel_y_out, pose.yaw_rate_out, pose.status};
				if (pose_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: pose beat with none due: %p", $realtime, got);
				end else begin
					want = pose_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: pose mismatch\n  exp %p\n  got %p",
								$realtime, want, got);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_MAX_STEP)
					lim_step = cfg.data;
				else if (cfg.index == CFG_STALE)
					lim_stale = cfg.data;
			end
			if (item.valid && item.ready) begin
				if (item.cmd == CMD_SENSOR) begin
					acc_x = item.accel_x;
					acc_y = item.accel_y;
					vel_x = item.vel_x_in;
					vel_y = item.vel_y_in;
					yaw = item.yaw_rate_in;
					age = 0;
				end else begin
					integrate_tick(longint'(item.step_time), want);
					pose_due.push_back(want);
				end
			end
			pending = pose_due.size();
		end
	end

endmodule

FILE: sim/planar_dead_reckoning_odometry_top_test.sv
`timescale 1ns / 100ps

module planar_dead_reckoning_odometry_top_test;
	import pdro_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;

	// Idle spread of each side; zero gives back-to-back stretches
	int   src_gap_max;
	int   snk_gap_max;
	bit   hold_sink;

	pdro_cfg_if  cfg();
	pdro_item_if item();
	pdro_pose_if pose();

	planar_dead_reckoning_odometry_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.pose   (pose)
	);

	pdro_pose_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item),
		.pose    (pose),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Give up well past the slowest legal run: ~850 items plus stalls
	initial begin
		#60000000;
		$display("planar_dead_reckoning_odometry_top test failed");
		$finish;
	end

	// Pose receiver: random hold-off per beat, plus one long hold on request
	initial begin
		int gap;
		pose.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				// hold off long enough for the block to back up onto the item side
				pose.ready = 1'b0;
				repeat (4000) @(negedge clk);
				hold_sink = 1'b0;
			end
			gap = $urandom_range(0, snk_gap_max);
			if (gap > 0) begin
				pose.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pose.ready = 1'b1;
			do @(posedge clk); while (!pose.valid);
		end
	end

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg.index = idx;
		cfg.data  = val;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Drop the item side, drain every pending pose, then let the block settle
	task automatic drain;
		@(negedge clk);
		item.valid = 1'b0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_beat(input logic [CMD_W-1:0] kind, input logic signed [SENS_W-1:0] ax,
		input logic signed [SENS_W-1:0] ay, input logic signed [SENS_W-1:0] vx,
		input logic signed [SENS_W-1:0] vy, input logic signed [SENS_W-1:0] yr,
		input logic [STEP_W-1:0] st);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			item.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.cmd         = kind;
		item.accel_x     = ax;
		item.accel_y     = ay;
		item.vel_x_in    = vx;
		item.vel_y_in    = vy;
		item.yaw_rate_in = yr;
		item.step_time   = st;
		item.valid       = 1'b1;
		do @(posedge clk); while (!item.ready);
	endtask

	task automatic send_tick(input logic [STEP_W-1:0] st);
		send_beat(CMD_TICK, SENS_W'($urandom), SENS_W'($urandom), SENS_W'($urandom),
			SENS_W'($urandom), SENS_W'($urandom), st);
	endtask

	// Sensor sample: mostly moderate motion, sometimes anything the fields hold
	task automatic send_sensor(input bit wide);
		if (wide)
			send_beat(CMD_SENSOR, SENS_W'($urandom), SENS_W'($urandom), SENS_W'($urandom),
				SENS_W'($urandom), SENS_W'($urandom), STEP_W'($urandom));
		else
			send_beat(CMD_SENSOR, SENS_W'($signed(20'($urandom))),
				SENS_W'($signed(20'($urandom))), SENS_W'($signed(22'($urandom))),
				SENS_W'($signed(22'($urandom))), SENS_W'($signed(23'($urandom))),
				STEP_W'($urandom));
	endtask

	// Mostly a sensor followed by a few in-range ticks, with noise mixed in
	task automatic random_run(input int count, input longint step_lim, input longint stale_lim);
		longint span;
		int k, done;
		span = (step_lim < stale_lim) ? step_lim : stale_lim;
		span = (span > 7) ? span / 7 : 1;
		done = 0;
		while (done < count) begin
			send_sensor($urandom_range(0, 3) == 0);
			done++;
			k = $urandom_range(1, 6);
			for (int j = 0; j < k && done < count; j++) begin
				case ($urandom_range(0, 19))
					0:       send_tick('0);
					1:       send_tick(STEP_W'($urandom));
					2:       send_tick(STEP_W'(step_lim));
					3:       send_tick(STEP_W'(step_lim - 1));
					default: send_tick(STEP_W'($urandom_range(1, int'(span))));
				endcase
				done++;
			end
		end
	endtask

	initial begin
		item.valid = 1'b0;
		item.cmd = CMD_SENSOR;
		item.accel_x = '0;
		item.accel_y = '0;
		item.vel_x_in = '0;
		item.vel_y_in = '0;
		item.yaw_rate_in = '0;
		item.step_time = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_MAX_STEP;
		cfg.data = '0;
		src_gap_max = 16;
		snk_gap_max = 16;
		hold_sink = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes under the reset limits
		send_tick(20'd10000);
		send_beat(CMD_SENSOR, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
			24'sh7FFFFF, 20'hFFFFF);
		send_tick(20'd99999);
		send_tick(20'd0);
		send_tick(20'd100000);
		send_beat(CMD_SENSOR, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000,
			24'sh800000, 20'h0);
		send_tick(20'd1);
		send_tick(20'd60000);
		// this tick takes the age past the stale limit
		send_tick(20'd60000);
		send_tick(20'hFFFFF);
		send_beat(CMD_SENSOR, '0, '0, '0, '0, '0, '0);
		send_tick(20'd5000);
		drain();

		// Widest limits: age saturation and long in-range steps
		put_reg(CFG_MAX_STEP, 20'hFFFFF);
		put_reg(CFG_STALE, 20'hFFFFF);
		send_sensor(1);
		send_tick(20'hFFFFE);
		send_tick(20'hFFFFE);
		send_tick(20'hFFFFE);
		drain();

		// Zero limits: every tick out of range, then every in-range tick stale
		put_reg(CFG_MAX_STEP, '0);
		put_reg(CFG_STALE, 20'd50000);
		send_sensor(0);
		send_tick(20'd1);
		send_tick(20'd30000);
		drain();
		put_reg(CFG_MAX_STEP, 20'd30000);
		put_reg(CFG_STALE, '0);
		send_sensor(0);
		send_tick(20'd1);
		send_tick(20'd29999);
		drain();

		// Random under reset values, back-to-back on both sides
		put_reg(CFG_MAX_STEP, MAX_STEP_RST);
		put_reg(CFG_STALE, STALE_RST);
		src_gap_max = 0;
		snk_gap_max = 0;
		random_run(80, MAX_STEP_RST, STALE_RST);
		src_gap_max = 16;
		snk_gap_max = 16;
		// long receiver hold while items keep coming
		hold_sink = 1'b1;
		random_run(170, MAX_STEP_RST, STALE_RST);
		drain();

		// Smallest limits: nothing integrates
		put_reg(CFG_MAX_STEP, 20'd1);
		put_reg(CFG_STALE, 20'd1);
		random_run(40, 1, 1);
		drain();

		put_reg(CFG_MAX_STEP, 20'hFFFFF);
		put_reg(CFG_STALE, 20'hFFFFF);
		random_run(150, 20'hFFFFF, 20'hFFFFF);
		drain();

		for (int p = 0; p < 4; p++) begin
			logic [CFG_DAT_W-1:0] ms, sl;
			ms = CFG_DAT_W'($urandom_range(1, 20'hFFFFF));
			sl = CFG_DAT_W'($urandom_range(1, 20'hFFFFF));
			put_reg(CFG_MAX_STEP, ms);
			put_reg(CFG_STALE, sl);
			src_gap_max = (p == 1) ? 0 : 16;
			snk_gap_max = (p == 2) ? 0 : 16;
			random_run(95, ms, sl);
			drain();
		end

		@(negedge clk);
		item.valid = 1'b0;
		wait (pending == 0);
		repeat (1000) @(posedge clk);
		if (errors == 0)
			$display("planar_dead_reckoning_odometry_top test passed");
		else
			$display("planar_dead_reckoning_odometry_top test failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/pdro_pkg.sv
rtl/core/pdro_if.sv
rtl/core/pdro_mul.sv
rtl/core/pdro_div.sv
rtl/core/pdro_cordic.sv
rtl/core/planar_dead_reckoning_odometry_top.sv
sim/pdro_pose_checker.sv
sim/planar_dead_reckoning_odometry_top_test.sv
